>>> src/ra_alu_pkg.sv
package ra_alu_pkg;

    localparam int unsigned DefaultValueWidth = 32;
    localparam int unsigned FieldWidth = 32;

    typedef enum logic [2:0] {
        KIND_LOAD   = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_SUB    = 3'd2,
        KIND_MUL    = 3'd3,
        KIND_DIV    = 3'd4,
        KIND_REDUCE = 3'd5
    } t_kind;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [FieldWidth-1:0] operand_num;
        logic signed [FieldWidth-1:0] operand_den;
    } t_in_item;

    typedef struct packed {
        logic signed [FieldWidth-1:0] result_num;
        logic signed [FieldWidth-1:0] result_den;
        logic signed [FieldWidth-1:0] whole_part;
        logic                         refused;
    } t_out_item;

endpackage

>>> src/rational_accumulator_alu.sv
// Every step runs on one shared shift-add unit, which does one multiply or divide at a time,
// bit by bit, so the run time is data-dependent. Load, multiply and divide use the unit for
// their products and the whole part; add, subtract and reduce also run a Euclid gcd loop of
// divides whose length depends on the operands. Throughput: one transaction at a time; the
// next is accepted the cycle after a result is registered, while that result may still wait in the output register.
// Reset: synchronous, active low; the held fraction returns to 1/1.
module rational_accumulator_alu
    import ra_alu_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = DefaultValueWidth
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    localparam int unsigned W = VALUE_WIDTH;
    localparam int unsigned CW = $clog2(W + 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DISP  = 11'b00000000010,
        S_GCD   = 11'b00000000100,
        S_GRUN  = 11'b00000001000,
        S_F1    = 11'b00000010000,
        S_F2    = 11'b00000100000,
        S_M1    = 11'b00001000000,
        S_M2    = 11'b00010000000,
        S_M3    = 11'b00100000000,
        S_WHOLE = 11'b01000000000,
        S_RUN   = 11'b10000000000
    } t_state;

    // Shared unit: op 0 multiply, op 1 unsigned divide.
    t_state r_state, n_state, r_ret, n_ret;
    logic [W-1:0] r_an, n_an, r_ad, n_ad, r_tn, n_tn, r_td, n_td;
    logic [2:0]   r_kind, n_kind;
    logic [W-1:0] r_ga, n_ga, r_gb, n_gb, r_fa, n_fa, r_fb, n_fb, r_p, n_p;
    logic [W-1:0] r_x, n_x, r_y, n_y, r_acc, n_acc, r_rem, n_rem;
    logic         r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]   r_step, n_step;
    logic         r_ovalid, n_ovalid, r_ref, n_ref;
    t_out_item    r_out, n_out;

    function automatic logic [W-1:0] magf(input logic [W-1:0] v);
        magf = v[W-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] from32(input logic [FieldWidth-1:0] v);
        logic [W+FieldWidth-1:0] e;
        e = {{W{v[FieldWidth-1]}}, v};
        from32 = e[W-1:0];
    endfunction

    function automatic logic [FieldWidth-1:0] to32(input logic [W-1:0] v);
        logic [W+FieldWidth-1:0] e;
        e = {{FieldWidth{v[W-1]}}, v};
        to32 = e[FieldWidth-1:0];
    endfunction

    logic [W:0] w_sub;
    assign w_sub = {r_rem[W-2:0], r_x[W-1], 1'b0} >> 1;

    logic [W:0] w_trial;
    assign w_trial = {1'b0, r_rem[W-2:0], r_x[W-1]} - {1'b0, r_y};

    always_comb begin
        n_state = r_state; n_ret = r_ret; n_an = r_an; n_ad = r_ad;
        n_tn = r_tn; n_td = r_td; n_kind = r_kind; n_ga = r_ga; n_gb = r_gb;
        n_fa = r_fa; n_fb = r_fb; n_p = r_p; n_x = r_x; n_y = r_y;
        n_acc = r_acc; n_rem = r_rem; n_op = r_op; n_cnt = r_cnt;
        n_step = r_step; n_ovalid = r_ovalid; n_ref = r_ref; n_out = r_out;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_kind = i_data.kind;
                    n_tn = from32(i_data.operand_num);
                    n_td = from32(i_data.operand_den);
                    n_ref = 1'b0;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_kind)
                    KIND_LOAD: begin
                        n_an = r_tn; n_ad = r_td; n_state = S_WHOLE;
                    end
                    KIND_ADD, KIND_SUB: begin
                        if (magf(r_ad) == '0 || magf(r_td) == '0) begin
                            n_ref = 1'b1; n_state = S_WHOLE;
                        end else begin
                            n_ga = magf(r_ad); n_gb = magf(r_td); n_state = S_GCD;
                        end
                    end
                    KIND_MUL, KIND_DIV: begin
                        n_step = 4'd0; n_state = S_M1;
                    end
                    KIND_REDUCE: begin
                        if (magf(r_an) == '0 || magf(r_ad) == '0) begin
                            n_ref = 1'b1; n_state = S_WHOLE;
                        end else begin
                            n_ga = magf(r_an); n_gb = magf(r_ad); n_state = S_GCD;
                        end
                    end
                    default: n_state = S_WHOLE;
                endcase
            end
            S_GCD: begin
                if (r_gb == '0) begin
                    n_step = 4'd0; n_state = S_F1;
                end else begin
                    n_op = 1'b1; n_x = r_ga; n_y = r_gb; n_rem = '0; n_acc = '0;
                    n_cnt = CW'(W); n_ret = S_GRUN; n_state = S_RUN;
                end
            end
            S_GRUN: begin
                n_ga = r_gb; n_gb = r_rem; n_state = S_GCD;
            end
            S_F1: begin
                // Divide the magnitude of a signed value by the gcd held in r_ga.
                n_op = 1'b1; n_y = r_ga; n_rem = '0; n_acc = '0; n_cnt = CW'(W);
                unique case (r_step)
                    4'd0: n_x = magf(r_kind == KIND_REDUCE ? r_an : r_td);
                    default: n_x = magf(r_ad);
                endcase
                n_ret = S_F2; n_state = S_RUN;
            end
            S_F2: begin
                logic neg;
                neg = (r_step == 4'd0) ? (r_kind == KIND_REDUCE ? r_an[W-1] : r_td[W-1])
                                       : r_ad[W-1];
                if (r_step == 4'd0) begin
                    n_fa = neg ? (~r_x + 1'b1) : r_x;
                    n_step = 4'd1; n_state = S_F1;
                end else begin
                    n_fb = neg ? (~r_x + 1'b1) : r_x;
                    if (r_kind == KIND_REDUCE) begin
                        n_an = r_fa; n_ad = neg ? (~r_x + 1'b1) : r_x;
                        n_state = S_WHOLE;
                    end else begin
                        n_step = 4'd2; n_state = S_M1;
                    end
                end
            end
            S_M1: begin
                n_op = 1'b0; n_acc = '0; n_cnt = CW'(W); n_ret = S_M2; n_state = S_RUN;
                unique case (r_step)
                    4'd0: begin n_x = r_an; n_y = (r_kind == KIND_MUL) ? r_tn : r_td; end
                    4'd1: begin n_x = r_ad; n_y = (r_kind == KIND_MUL) ? r_td : r_tn; end
                    4'd2: begin n_x = r_fb; n_y = r_td; end
                    4'd3: begin n_x = r_an; n_y = r_fa; end
                    default: begin n_x = r_tn; n_y = r_fb; end
                endcase
            end
            S_M2: begin
                n_state = S_M1;
                unique case (r_step)
                    4'd0: begin n_p = r_acc; n_step = 4'd1; end
                    4'd1: begin n_an = r_p; n_ad = r_acc; n_state = S_WHOLE; end
                    4'd2: begin n_p = r_acc; n_step = 4'd3; n_gb = r_acc; end
                    4'd3: begin n_ga = r_acc; n_step = 4'd4; end
                    default: n_state = S_M3;
                endcase
            end
            S_M3: begin
                n_an = (r_kind == KIND_ADD) ? r_ga + r_acc : r_ga - r_acc;
                n_ad = r_gb;
                n_state = S_WHOLE;
            end
            S_WHOLE: begin
                if (r_step == 4'd15) begin
                    if (!r_ovalid || i_ready) begin
                        n_out.result_num = to32(r_an);
                        n_out.result_den = to32(r_ad);
                        n_out.whole_part = (r_ad == '0) ? '0 :
                            to32((r_an[W-1] ^ r_ad[W-1]) ? (~r_x + 1'b1) : r_x);
                        n_out.refused = r_ref;
                        n_ovalid = 1'b1; n_step = 4'd0; n_state = S_IDLE;
                    end
                end else if (r_ad == '0) begin
                    n_step = 4'd15; n_x = '0;
                end else begin
                    n_op = 1'b1; n_x = magf(r_an); n_y = magf(r_ad); n_rem = '0;
                    n_acc = '0; n_cnt = CW'(W); n_step = 4'd15; n_ret = S_WHOLE;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == '0) begin
                    if (!r_op) begin
                        n_x = r_acc;
                    end
                    n_state = r_ret;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    if (r_op) begin
                        if (!w_trial[W]) begin
                            n_rem = w_trial[W-1:0];
                            n_x = {r_x[W-2:0], 1'b1};
                        end else begin
                            n_rem = {r_rem[W-2:0], r_x[W-1]};
                            n_x = {r_x[W-2:0], 1'b0};
                        end
                        if (r_rem[W-1]) begin
                            n_rem = w_sub[W-1:0] - r_y;
                            n_x = {r_x[W-2:0], 1'b1};
                        end
                    end else begin
                        n_acc = {r_acc[W-2:0], 1'b0} + (r_x[W-1] ? r_y : '0);
                        n_x = {r_x[W-2:0], 1'b0};
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_ret <= S_IDLE;
            r_an <= W'(1); r_ad <= W'(1);
            r_ovalid <= 1'b0; r_step <= 4'd0; r_cnt <= '0; r_op <= 1'b0;
        end else begin
            r_state <= n_state; r_ret <= n_ret; r_an <= n_an; r_ad <= n_ad;
            r_ovalid <= n_ovalid; r_step <= n_step; r_cnt <= n_cnt; r_op <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tn <= n_tn; r_td <= n_td; r_kind <= n_kind; r_ga <= n_ga; r_gb <= n_gb;
        r_fa <= n_fa; r_fb <= n_fb; r_p <= n_p; r_x <= n_x; r_y <= n_y;
        r_acc <= n_acc; r_rem <= n_rem; r_ref <= n_ref; r_out <= n_out;
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data)) else $error("output changed");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid || r_state == S_IDLE) else $error("ready while busy");
    a_idle_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_state == S_DISP) else $error("no dispatch");
`endif

endmodule
